@@ rtl/mmh_pkg.sv @@
// Shared types, constants and helper functions for the MurmurHash3 x86_32 stream hasher.
// Has no dependencies; every other file in rtl/ imports it.
package mmh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned QCNT_W  = 2;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'hDEADBEEF;
    localparam logic [WORD_W-1:0] MIX_C1     = 32'hCC9E2D51;
    localparam logic [WORD_W-1:0] MIX_C2     = 32'h1B873593;
    localparam logic [WORD_W-1:0] MIX_ADD    = 32'hE6546B64;
    localparam logic [WORD_W-1:0] FIN_M1     = 32'h85EBCA6B;
    localparam logic [WORD_W-1:0] FIN_M2     = 32'hC2B2AE35;

    localparam logic [COUNT_W-1:0] CNT_FULL = 3'd4;

    // Classified message word as it travels from front to back.
    typedef struct packed {
        logic [WORD_W-1:0]  word;   // unused bytes already cleared
        logic [COUNT_W-1:0] count;  // clamped to 0..4
        logic               last;
        logic               full;   // four bytes: mix as a full block
        logic               err;    // short non-last word
    } item_t;

    // Status of the back end seen by the top level.
    typedef struct packed {
        logic busy;
        logic mid;
    } back_stat_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input logic [4:0] n);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << n;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        return (c > CNT_FULL) ? CNT_FULL : c;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] c);
        logic [WORD_W-1:0] m;
        case (c)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/mmh_if.sv @@
// Handshake channel interfaces: message words in, hash results out, seed writes.
// Depends on mmh_pkg for field widths.
interface mmh_in_if
    import mmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   data_word;
    logic [COUNT_W-1:0]  byte_count;
    logic                last_item;

    modport source (output valid, data_word, byte_count, last_item, input ready);
    modport sink   (input valid, data_word, byte_count, last_item, output ready);
endinterface

interface mmh_out_if
    import mmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   hash_value;
    logic                framing_error;

    modport source (output valid, hash_value, framing_error, input ready);
    modport sink   (input valid, hash_value, framing_error, output ready);
endinterface

interface mmh_cfg_if
    import mmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   seed;

    modport source (output valid, seed, input ready);
    modport sink   (input valid, seed, output ready);
endinterface

@@ rtl/mmh_front.sv @@
// Front end: registers each input beat and classifies it (clamp, mask, error flag).
// Depends on mmh_pkg and mmh_in_if.
module mmh_front
    import mmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mmh_in_if.sink    in_ch,
    output logic      item_valid,
    input  logic      item_ready,
    output item_t     item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [COUNT_W-1:0] cnt;

    assign in_ch.ready = !valid_reg || item_ready;
    assign item_valid  = valid_reg;
    assign item        = item_reg;

    always_comb
    begin
        cnt             = clamp_count(in_ch.byte_count);
        item_next.word  = in_ch.data_word & byte_mask(cnt);
        item_next.count = cnt;
        item_next.last  = in_ch.last_item;
        item_next.full  = (cnt == CNT_FULL);
        item_next.err   = !in_ch.last_item && (cnt != CNT_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    // Capture the payload on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/mmh_queue.sv @@
// Short FIFO of classified items between front and back ends.
// Depends on mmh_pkg.
module mmh_queue
    import mmh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/mmh_back.sv @@
// Back end: multi-cycle mixing sequencer, final avalanche and output register.
// Depends on mmh_pkg and mmh_out_if.
module mmh_back
    import mmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] seed,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    mmh_out_if.source         out_ch,
    output back_stat_t        stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MIX,
        S_FIN1,
        S_FIN2,
        S_DONE,
        S_ERR
    } state_t;

    state_t             state_reg;
    logic               mid_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_hash_reg;
    logic               out_err_reg;
    logic [WORD_W-1:0]  h_reg;
    logic [WORD_W-1:0]  len_reg;
    logic [WORD_W-1:0]  k_reg;
    logic               full_reg;
    logic               last_reg;

    logic               out_free;
    logic [WORD_W-1:0]  hx;
    logic [WORD_W-1:0]  hr;
    logic [WORD_W-1:0]  hl;
    logic [WORD_W-1:0]  fa;
    logic [WORD_W-1:0]  fb;

    assign item_ready           = (state_reg == S_IDLE);
    assign out_free             = !out_valid_reg || out_ch.ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.hash_value    = out_hash_reg;
    assign out_ch.framing_error = out_err_reg;
    assign stat.busy            = (state_reg != S_IDLE);
    assign stat.mid             = mid_reg;

    always_comb
    begin
        hx = h_reg ^ k_reg;
        hr = rotl(hx, 5'd13);
        hl = h_reg ^ len_reg;
        fa = hl ^ (hl >> 16);
        fb = k_reg ^ (k_reg >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a finished result when the output slot is free; otherwise
            // drop the output beat once taken.
            if ((state_reg == S_DONE || state_reg == S_ERR) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= item.err ? S_ERR : S_MUL1;
                        mid_reg   <= !item.err;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    state_reg <= last_reg ? S_FIN1 : S_IDLE;
                end
                S_FIN1:
                begin
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE, S_ERR:
                begin
                    if (out_free)
                    begin
                        mid_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: one multiplier step per state, registered between steps.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !item.err)
                begin
                    k_reg    <= item.word;
                    full_reg <= item.full;
                    last_reg <= item.last;
                    if (!mid_reg)
                    begin
                        h_reg   <= seed;
                        len_reg <= WORD_W'(item.count);
                    end
                    else
                    begin
                        len_reg <= len_reg + WORD_W'(item.count);
                    end
                end
            end
            S_MUL1:
            begin
                k_reg <= k_reg * MIX_C1;
            end
            S_MUL2:
            begin
                k_reg <= rotl(k_reg, 5'd15) * MIX_C2;
            end
            S_MIX:
            begin
                h_reg <= full_reg ? ((hr << 2) + hr + MIX_ADD) : hx;
            end
            S_FIN1:
            begin
                k_reg <= fa * FIN_M1;
            end
            S_FIN2:
            begin
                k_reg <= fb * FIN_M2;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_hash_reg <= k_reg ^ (k_reg >> 16);
                    out_err_reg  <= 1'b0;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_hash_reg <= '0;
                    out_err_reg  <= 1'b1;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

endmodule

@@ rtl/murmur3_32_hash_stream.sv @@
// Path of a last word: the front register, the queue, then the back-end states
// S_IDLE, S_MUL1, S_MUL2, S_MIX, S_FIN1, S_FIN2 and S_DONE, then the output register.
// Each word passes S_IDLE, S_MUL1, S_MUL2 and S_MIX, and the two multiply steps set
// the pace; no new word is taken before S_IDLE. The final avalanche ends each message.
// Reset: rst_n is asynchronous, active low; it empties the queue and pipeline,
// restores the seed to its default and starts a fresh message.
module murmur3_32_hash_stream
    import mmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mmh_in_if.sink    in_stream,
    mmh_out_if.source out_stream,
    mmh_cfg_if.sink   cfg
);

    // Seed register: always writable; a new value is picked up at the
    // first word of the next message.
    logic [WORD_W-1:0] seed_reg;

    // Front-to-queue and queue-to-back item beats.
    logic       front_valid;
    logic       front_ready;
    item_t      front_item;
    logic       back_valid;
    logic       back_ready;
    item_t      back_item;
    back_stat_t back_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg.valid)
        begin
            seed_reg <= cfg.seed;
        end
    end

    // Register and classify each incoming word.
    mmh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_stream),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // Decouple front and back so each can stall on its own.
    mmh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // Mix words, finish the message and hold the result beat.
    mmh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_reg),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .out_ch     (out_stream),
        .stat       (back_stat)
    );

`ifndef ASSERT_OFF
    // A framing error result always carries a zero hash.
    a_err_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid && out_stream.framing_error |-> out_stream.hash_value == '0)
        else $error("framing error result with nonzero hash");

    // A result beat only appears after the back end was working on something.
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_stream.valid) |-> $past(back_stat.busy))
        else $error("result appeared while back end was idle");

    // The back end takes an item only while idle and is busy after taking it.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && back_ready |=> back_stat.busy)
        else $error("back end did not start on a popped item");
`endif

endmodule

@@ dv/murmur3_32_hash_stream_tb.sv @@
// Self-checking testbench for the MurmurHash3 x86_32 stream hasher: directed framing cases,
// seed register updates and random message streams under sender and receiver stalls.
// Depends on mmh_pkg, the mmh_*_if interfaces and the murmur3_32_hash_stream RTL.
module murmur3_32_hash_stream_tb;
    import mmh_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int WATCHDOG_CYCLES = 4000;
    // Cycles to let the mixer finish words that produce no result
    // (front register and queue of two ahead of the back-end mixer).
    localparam int SETTLE_CYCLES   = 32;

    typedef struct packed {
        logic [WORD_W-1:0] hash;
        logic              frame_err;
    } hash_result_t;

    logic clk;
    logic rst_n;

    mmh_in_if  in_if ();
    mmh_out_if out_if ();
    mmh_cfg_if cfg_if ();

    murmur3_32_hash_stream dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg        (cfg_if)
    );

    always #10 clk = ~clk;

    // Hasher state as the testbench sees it; advanced on every accepted beat.
    logic [WORD_W-1:0] seed_shadow;
    logic [WORD_W-1:0] running_hash;
    logic [WORD_W-1:0] msg_bytes;
    logic              msg_open;

    // Hashes and framing errors still owed by the block, oldest first.
    hash_result_t pending_hashes[$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatch_count;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Hash arithmetic
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [WORD_W-1:0] scramble_block(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] t;
        t = k * MIX_C1;
        t = rotl32(t, 15);
        t = t * MIX_C2;
        return t;
    endfunction

    function automatic logic [WORD_W-1:0] final_mix(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    task automatic restart_message();
        running_hash = seed_shadow;
        msg_bytes    = '0;
        msg_open     = 1'b0;
    endtask

    // Fold one accepted word into the running hash and queue any result it causes.
    task automatic fold_word(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] c,
                             input logic l);
        logic [WORD_W-1:0]  h;
        logic [WORD_W-1:0]  mask;
        logic [COUNT_W-1:0] n;
        // Counts above four behave as a full word.
        n = (c > CNT_FULL) ? CNT_FULL : c;
        // The seed is latched by the first word of a message.
        if (!msg_open)
        begin
            running_hash = seed_shadow;
            msg_bytes    = '0;
            msg_open     = 1'b1;
        end
        h = running_hash;
        // Short word before the end: flag it and drop the message.
        if (!l && n < CNT_FULL)
        begin
            pending_hashes.push_back('{hash: '0, frame_err: 1'b1});
            restart_message();
            return;
        end
        if (n == CNT_FULL)
        begin
            h = h ^ scramble_block(w);
            h = rotl32(h, 13);
            h = h * 5 + MIX_ADD;
        end
        else if (n != '0)
        begin
            // Tail bytes: mask off unused bytes, skip the rotate-multiply on h.
            mask = (32'h1 << (8 * int'(n))) - 1;
            h = h ^ scramble_block(w & mask);
        end
        msg_bytes = msg_bytes + WORD_W'(n);
        if (!l)
        begin
            running_hash = h;
            return;
        end
        h = h ^ msg_bytes;
        pending_hashes.push_back('{hash: final_mix(h), frame_err: 1'b0});
        restart_message();
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Send one message word. Valid is only dropped when the sender idles, so a
    // back-to-back beat never sees two assignments to valid in one time step.
    task automatic push_word(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] c,
                             input logic l);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid      <= 1'b1;
        in_if.data_word  <= w;
        in_if.byte_count <= c;
        in_if.last_item  <= l;
        do @(posedge clk); while (!in_if.ready);
        fold_word(w, c, l);
    endtask

    // Hold the input low, wait out every owed result, then let the mixer settle
    // so that words with no result are fully absorbed before a seed write.
    task automatic drain_block();
        in_if.valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        // A new seed reaches the running hash only when no message is open.
        seed_shadow = v;
        if (!msg_open)
            running_hash = seed_shadow;
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker, receiver stalls and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        hash_result_t want;
        if (out_if.valid && out_if.ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                report_mismatch("unexpected result beat", out_if.hash_value, '0);
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (out_if.hash_value !== want.hash)
                    report_mismatch("hash_value", out_if.hash_value, want.hash);
                if (out_if.framing_error !== want.frame_err)
                    report_mismatch("framing_error", WORD_W'(out_if.framing_error),
                                    WORD_W'(want.frame_err));
            end
        end
        // Stall the result channel at random per the current idle mix.
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);

        // Any beat on any channel counts as progress.
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no beat for %0d cycles at %0t", quiet_cycles, $realtime);
            $display("murmur3_32_hash_stream regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, tails, oversized counts, empty message and framing errors,
    // all under the reset seed.
    task automatic test_directed_framing();
        // Empty message: only the final mix of the seed, junk data ignored.
        push_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        // Single full words at the data extremes.
        push_word(32'h0000_0000, 3'd4, 1'b1);
        push_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        // One-, two- and three-byte tails with set bits in the unused bytes.
        push_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        push_word(32'hA5A5_A5A5, 3'd2, 1'b1);
        push_word(32'h1234_5678, 3'd3, 1'b1);
        // Oversized counts act as four, both mid-message and on the last word.
        push_word(32'hDEAD_BEEF, 3'd5, 1'b0);
        push_word(32'h0F0F_F0F0, 3'd7, 1'b1);
        push_word(32'h8000_0001, 3'd6, 1'b1);
        // Multi-word message ending in a tail.
        push_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        push_word(32'h0000_0000, 3'd4, 1'b0);
        push_word(32'hCAFE_F00D, 3'd2, 1'b1);
        // Short words before the end: framing error, message dropped.
        push_word(32'h1111_1111, 3'd0, 1'b0);
        push_word(32'h2222_2222, 3'd1, 1'b0);
        push_word(32'h3333_3333, 3'd3, 1'b0);
        // Error after a good word, then a clean message from the seed.
        push_word(32'h4444_4444, 3'd4, 1'b0);
        push_word(32'h5555_5555, 3'd2, 1'b0);
        push_word(32'h6666_6666, 3'd4, 1'b1);
        // Full-word message whose last word is also full.
        push_word(32'h7FFF_FFFF, 3'd4, 1'b0);
        push_word(32'h8000_0000, 3'd4, 1'b1);
    endtask

    // Seed writes in the middle of a message and just before one.
    task automatic test_seed_updates();
        drain_block();
        push_word(32'h0123_4567, 3'd4, 1'b0);
        push_word(32'h89AB_CDEF, 3'd4, 1'b0);
        // Open message keeps its old seed; the new one applies to the next message.
        drain_block();
        write_seed(32'h0000_0000);
        push_word(32'hFEDC_BA98, 3'd3, 1'b1);
        push_word(32'h7654_3210, 3'd4, 1'b1);
        // Written before the first word, so it applies to this message.
        drain_block();
        write_seed(32'hFFFF_FFFF);
        push_word(32'h0000_0000, 3'd0, 1'b1);
        push_word(32'h5A5A_5A5A, 3'd4, 1'b1);
    endtask

    // One random message: mostly well formed; one in ten with more than one word is
    // broken by a short word before its end. Return the number of words sent.
    task automatic send_random_message(output int sent);
        int words;
        int bad_at;
        logic [COUNT_W-1:0] c;
        words  = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        bad_at = -1;
        if (words > 1 && $urandom_range(9) == 0)
            bad_at = $urandom_range(words - 2, 0);
        sent = 0;
        for (int i = 0; i < words; i++)
        begin
            sent++;
            if (i == words - 1)
            begin
                push_word($urandom, COUNT_W'($urandom_range(7, 0)), 1'b1);
            end
            else if (i == bad_at)
            begin
                push_word($urandom, COUNT_W'($urandom_range(3, 0)), 1'b0);
                return;
            end
            else
            begin
                c = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(7, 5)) : CNT_FULL;
                push_word($urandom, c, 1'b0);
            end
        end
    endtask

    task automatic test_random_stream(input int n_items, input logic [WORD_W-1:0] seed_val,
                                      input int src_pct, input int sink_pct);
        int total;
        int sent;
        drain_block();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        write_seed(seed_val);
        total = 0;
        while (total < n_items)
        begin
            send_random_message(sent);
            total += sent;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_word  = '0;
        in_if.byte_count = '0;
        in_if.last_item  = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.seed      = '0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        src_idle_pct     = 26;
        sink_idle_pct    = 53;
        seed_shadow      = SEED_RESET;
        restart_message();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_framing();
        test_seed_updates();
        // Sender idles lightly, receiver heavily; then swap; then full rate.
        test_random_stream(470, $urandom, 26, 53);
        test_random_stream(470, 32'hFFFF_FFFF, 53, 26);
        test_random_stream(470, 32'h0000_0000, 0, 0);

        drain_block();
        if (mismatch_count == 0)
            $display("murmur3_32_hash_stream regression: pass");
        else
            $display("murmur3_32_hash_stream regression: fail");
        $finish;
    end

endmodule
